FILE: sv/kqt_pkg.sv
// ----------------------------------------------------------------------------
// kqt_pkg
// Shared types and codes for the keyed quantity table and its cell chain.
// ----------------------------------------------------------------------------
package kqt_pkg;

    localparam int DEFAULT_CAPACITY = 64;
    localparam int DATA_W           = 32;

    typedef logic [1:0] opcode_t;
    localparam opcode_t OP_INSERT = 2'd0;
    localparam opcode_t OP_SEARCH = 2'd1;
    localparam opcode_t OP_UPDATE = 2'd2;
    localparam opcode_t OP_DUMP   = 2'd3;

    typedef logic [2:0] status_t;
    localparam status_t ST_OK      = 3'd0;
    localparam status_t ST_FULL    = 3'd1;
    localparam status_t ST_DUP     = 3'd2;
    localparam status_t ST_MISSING = 3'd3;
    localparam status_t ST_EMPTY   = 3'd4;

    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_COMPARE,
        CMD_INSERT,
        CMD_WRITE,
        CMD_ROTATE
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t                 cmd;
        logic signed [DATA_W-1:0]  arg_key;
        logic signed [DATA_W-1:0]  arg_qty;
    } cell_ctrl_t;

endpackage

FILE: sv/kqt_cell.sv
// ----------------------------------------------------------------------------
// kqt_cell
// One entry of the sorted chain: holds a key and quantity, flags a key match
// and a key below the probe, shifts right on insert, left on dump rotation.
// ----------------------------------------------------------------------------
module kqt_cell
    import kqt_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cell_ctrl_t               ctrl,
    input  logic                     occ,
    input  logic                     left_occ,
    input  logic                     left_less,
    input  logic signed [DATA_W-1:0] left_key,
    input  logic signed [DATA_W-1:0] left_qty,
    input  logic signed [DATA_W-1:0] right_key,
    input  logic signed [DATA_W-1:0] right_qty,
    output logic signed [DATA_W-1:0] key,
    output logic signed [DATA_W-1:0] qty,
    output logic                     less,
    output logic                     hit
);

    logic signed [DATA_W-1:0] key_reg;
    logic signed [DATA_W-1:0] qty_reg;
    logic signed [DATA_W-1:0] key_next;
    logic signed [DATA_W-1:0] qty_next;
    logic                     less_reg;
    logic                     less_next;
    logic                     hit_reg;
    logic                     hit_next;

    always_comb
    begin
        key_next  = key_reg;
        qty_next  = qty_reg;
        less_next = less_reg;
        hit_next  = hit_reg;
        case (ctrl.cmd)
            CMD_COMPARE:
            begin
                less_next = occ && (key_reg < ctrl.arg_key);
                hit_next  = occ && (key_reg == ctrl.arg_key);
            end
            CMD_INSERT:
            begin
                if (left_occ && !left_less)
                begin
                    key_next = left_key;
                    qty_next = left_qty;
                end
                else if (left_occ && !less_reg)
                begin
                    key_next = ctrl.arg_key;
                    qty_next = ctrl.arg_qty;
                end
            end
            CMD_WRITE:
            begin
                if (hit_reg)
                begin
                    qty_next = ctrl.arg_qty;
                end
            end
            CMD_ROTATE:
            begin
                key_next = right_key;
                qty_next = right_qty;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            less_reg <= 1'b0;
            hit_reg  <= 1'b0;
        end
        else
        begin
            less_reg <= less_next;
            hit_reg  <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        qty_reg <= qty_next;
    end

    assign key  = key_reg;
    assign qty  = qty_reg;
    assign less = less_reg;
    assign hit  = hit_reg;

endmodule

FILE: sv/keyed_quantity_table.sv
// ----------------------------------------------------------------------------
// keyed_quantity_table
// Key/quantity table kept sorted in a chain of cells; insert, search,
// update and sorted dump.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------
//  in      | in_valid / in_ready  | opcode, key, amount
//  out     | out_valid / out_ready| status, out_key, quantity, last
//
//  Insert, search, update: one item at a time; compare in all cells at
//  accept, then resolve and write back once the output register is free.
//  Dump: the chain rotates once round, one cell per cycle unless a result
//  is stalled, emitting the first count_reg items in ascending key order.
//  Reset clears count and control regs, not cell data (unused until written).
//  A stalled output holds the result register; the table pauses behind it.
// ----------------------------------------------------------------------------
module keyed_quantity_table
    import kqt_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [1:0]               opcode,
    input  logic signed [DATA_W-1:0] key,
    input  logic signed [DATA_W-1:0] amount,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [2:0]               status,
    output logic signed [DATA_W-1:0] out_key,
    output logic signed [DATA_W-1:0] quantity,
    output logic                     last
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_APPLY,
        S_DUMP
    } state_t;

    state_t                   state_reg;
    state_t                   state_next;
    opcode_t                  op_reg;
    logic signed [DATA_W-1:0] key_reg;
    logic signed [DATA_W-1:0] amount_reg;
    logic [CW-1:0]            count_reg;
    logic [CW-1:0]            count_next;
    logic [SW-1:0]            step_reg;
    logic [SW-1:0]            step_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    status_t                  status_reg;
    status_t                  status_next;
    logic signed [DATA_W-1:0] out_key_reg;
    logic signed [DATA_W-1:0] out_key_next;
    logic signed [DATA_W-1:0] quantity_reg;
    logic signed [DATA_W-1:0] quantity_next;
    logic                     last_reg;
    logic                     last_next;

    cell_ctrl_t               ctrl;
    logic signed [DATA_W-1:0] cell_key [CAPACITY];
    logic signed [DATA_W-1:0] cell_qty [CAPACITY];
    logic                     cell_less [CAPACITY];
    logic                     cell_hit  [CAPACITY];
    logic                     cell_occ  [CAPACITY];

    logic                     any_hit;
    logic signed [DATA_W-1:0] sel_qty;
    logic signed [DATA_W-1:0] upd_qty;
    logic                     out_free;
    logic                     in_take;
    logic                     full;
    logic [CW-1:0]            step_ext;
    logic                     dump_emit;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            assign cell_occ[gi] = count_reg > CW'(gi);
            if (gi == 0)
            begin : g_head
                kqt_cell u_cell (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .ctrl      (ctrl),
                    .occ       (cell_occ[gi]),
                    .left_occ  (1'b1),
                    .left_less (1'b1),
                    .left_key  (ctrl.arg_key),
                    .left_qty  (ctrl.arg_qty),
                    .right_key (cell_key[(gi + 1) % CAPACITY]),
                    .right_qty (cell_qty[(gi + 1) % CAPACITY]),
                    .key       (cell_key[gi]),
                    .qty       (cell_qty[gi]),
                    .less      (cell_less[gi]),
                    .hit       (cell_hit[gi])
                );
            end
            else
            begin : g_body
                kqt_cell u_cell (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .ctrl      (ctrl),
                    .occ       (cell_occ[gi]),
                    .left_occ  (cell_occ[gi - 1]),
                    .left_less (cell_less[gi - 1]),
                    .left_key  (cell_key[gi - 1]),
                    .left_qty  (cell_qty[gi - 1]),
                    .right_key (cell_key[(gi + 1) % CAPACITY]),
                    .right_qty (cell_qty[(gi + 1) % CAPACITY]),
                    .key       (cell_key[gi]),
                    .qty       (cell_qty[gi]),
                    .less      (cell_less[gi]),
                    .hit       (cell_hit[gi])
                );
            end
        end
    endgenerate

    always_comb
    begin
        any_hit = 1'b0;
        sel_qty = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            any_hit = any_hit | cell_hit[i];
            sel_qty = sel_qty | (cell_qty[i] & {DATA_W{cell_hit[i]}});
        end
    end

    assign upd_qty   = sel_qty + amount_reg;
    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign in_take   = in_valid && in_ready;
    assign full      = count_reg >= CW'(CAPACITY);
    assign step_ext  = CW'(step_reg);
    assign dump_emit = step_ext < count_reg;

    always_comb
    begin
        ctrl.cmd     = CMD_HOLD;
        ctrl.arg_key = key_reg;
        ctrl.arg_qty = amount_reg;
        case (state_reg)
            S_IDLE:
            begin
                ctrl.arg_key = key;
                if (in_take)
                begin
                    ctrl.cmd = CMD_COMPARE;
                end
            end
            S_APPLY:
            begin
                if (out_free)
                begin
                    if (op_reg == OP_INSERT && !full && !any_hit)
                    begin
                        ctrl.cmd = CMD_INSERT;
                    end
                    else if (op_reg == OP_UPDATE && any_hit)
                    begin
                        ctrl.cmd     = CMD_WRITE;
                        ctrl.arg_qty = upd_qty;
                    end
                end
            end
            S_DUMP:
            begin
                if (out_free || !dump_emit)
                begin
                    ctrl.cmd = CMD_ROTATE;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;
        out_key_next   = out_key_reg;
        quantity_next  = quantity_reg;
        last_next      = last_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                if (out_free)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                    last_next      = 1'b1;
                    out_key_next   = key_reg;
                    quantity_next  = '0;
                    case (op_reg)
                        OP_INSERT:
                        begin
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else if (any_hit)
                            begin
                                status_next = ST_DUP;
                            end
                            else
                            begin
                                status_next   = ST_OK;
                                quantity_next = amount_reg;
                                count_next    = count_reg + CW'(1);
                            end
                        end
                        OP_SEARCH:
                        begin
                            status_next = any_hit ? ST_OK : ST_MISSING;
                            if (any_hit)
                            begin
                                quantity_next = sel_qty;
                            end
                        end
                        OP_UPDATE:
                        begin
                            status_next = any_hit ? ST_OK : ST_MISSING;
                            if (any_hit)
                            begin
                                quantity_next = upd_qty;
                            end
                        end
                        default:
                        begin
                            status_next  = ST_EMPTY;
                            out_key_next = '0;
                            if (count_reg != '0)
                            begin
                                state_next     = S_DUMP;
                                step_next      = '0;
                                out_valid_next = 1'b0;
                            end
                        end
                    endcase
                end
            end
            S_DUMP:
            begin
                if (out_free || !dump_emit)
                begin
                    if (dump_emit)
                    begin
                        out_valid_next = 1'b1;
                        status_next    = ST_OK;
                        out_key_next   = cell_key[0];
                        quantity_next  = cell_qty[0];
                        last_next      = (step_ext + CW'(1)) == count_reg;
                    end
                    step_next = step_reg + SW'(1);
                    if (step_ext == CW'(CAPACITY - 1))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            status_reg    <= ST_OK;
            out_key_reg   <= '0;
            quantity_reg  <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            status_reg    <= status_next;
            out_key_reg   <= out_key_next;
            quantity_reg  <= quantity_next;
            last_reg      <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            op_reg     <= opcode;
            key_reg    <= key;
            amount_reg <= amount;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign out_key   = out_key_reg;
    assign quantity  = quantity_reg;
    assign last      = last_reg;

endmodule

FILE: sv/kqt_checker.sv
// ----------------------------------------------------------------------------
// kqt_checker
// Port-level checks for the keyed quantity table, bound to the top level.
// ----------------------------------------------------------------------------
module kqt_checker
    import kqt_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_ready,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic [2:0]               status,
    input logic signed [DATA_W-1:0] out_key,
    input logic signed [DATA_W-1:0] quantity,
    input logic                     last
);

    a_one_item_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted back to back");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(status)
            && $stable(out_key) && $stable(quantity) && $stable(last)))
        else $error("stalled result changed");

    a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_OK) |-> (last && quantity == '0))
        else $error("error result not final or carries quantity");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_EMPTY) |-> (out_key == '0))
        else $error("empty result carries a key");

endmodule

bind keyed_quantity_table kqt_checker u_kqt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .out_key   (out_key),
    .quantity  (quantity),
    .last      (last)
);
